/* design/lndg_pkg.sv */
// Shared constants, control-word type and microprogram for the drift generator.
package lndg_pkg;

    // Default sizes for the top-level parameters
    localparam int PHASE_BITS_DEF = 24;
    localparam int SINE_DEPTH_DEF = 256;

    // Field widths
    localparam int DEPTH_W = 17;
    localparam int NOISE_W = 16;
    localparam int BT_W    = 24;
    localparam int FILT_W  = 18;
    localparam int ACC_W   = 19;
    localparam int LFO_W   = 18;
    localparam int GAIN_W  = 17;
    localparam int DIFF_W  = 19;
    localparam int TDATA_W = 40;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Fixed-point constants
    localparam logic [BT_W-1:0]    BT_RESET    = 24'd195225;
    localparam logic [DEPTH_W-1:0] FULL_SCALE  = 17'd65536;
    localparam logic [31:0]        HALF_PI_Q30 = 32'd1686629713;
    localparam logic [15:0]        SINE_PEAK   = 16'd32767;

    localparam logic signed [MUL_B_W-1:0] K_SLOW   = 22'sd19661;
    localparam logic signed [MUL_B_W-1:0] K_MID    = 22'sd45875;
    localparam logic signed [MUL_B_W-1:0] K_FAST   = 22'sd72090;
    localparam logic signed [MUL_B_W-1:0] GAIN_C   = 22'sd2058874;
    localparam logic signed [MUL_B_W-1:0] INV175   = 22'sd37449;
    localparam logic signed [MUL_B_W-1:0] POINT2   = 22'sd13107;

    localparam logic signed [FILT_W-1:0] FILT_MAX = 18'sd131071;
    localparam logic signed [FILT_W-1:0] FILT_MIN = -18'sd131072;

    // Multiplier operand selects
    localparam logic [2:0] MUL_NONE      = 3'd0;
    localparam logic [2:0] MUL_BT_K      = 3'd1;
    localparam logic [2:0] MUL_SUM_INV   = 3'd2;
    localparam logic [2:0] MUL_BT_GAIN   = 3'd3;
    localparam logic [2:0] MUL_G_DIFF    = 3'd4;
    localparam logic [2:0] MUL_FILT_P2   = 3'd5;
    localparam logic [2:0] MUL_LEV_DEPTH = 3'd6;

    // Write-back operations
    localparam logic [3:0] WB_NONE  = 4'd0;
    localparam logic [3:0] WB_INIT  = 4'd1;
    localparam logic [3:0] WB_PHASE = 4'd2;
    localparam logic [3:0] WB_ROM   = 4'd3;
    localparam logic [3:0] WB_ACC   = 4'd4;
    localparam logic [3:0] WB_LFO   = 4'd5;
    localparam logic [3:0] WB_GAIN  = 4'd6;
    localparam logic [3:0] WB_FILT  = 4'd7;
    localparam logic [3:0] WB_LEVEL = 4'd8;
    localparam logic [3:0] WB_OUT   = 4'd9;
    localparam logic [3:0] WB_ZERO  = 4'd10;

    // Jump conditions
    localparam logic [1:0] COND_NONE       = 2'd0;
    localparam logic [1:0] COND_DEPTH_ZERO = 2'd1;
    localparam logic [1:0] COND_LANE_MORE  = 2'd2;

    // Program addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_CHECK     = 4'd0;
    localparam logic [PC_W-1:0] PC_LOOP      = 4'd1;
    localparam logic [PC_W-1:0] PC_PHASE     = 4'd2;
    localparam logic [PC_W-1:0] PC_ROM       = 4'd3;
    localparam logic [PC_W-1:0] PC_ACC       = 4'd4;
    localparam logic [PC_W-1:0] PC_LFO_MUL   = 4'd5;
    localparam logic [PC_W-1:0] PC_LFO       = 4'd6;
    localparam logic [PC_W-1:0] PC_GAIN      = 4'd7;
    localparam logic [PC_W-1:0] PC_FILT_MUL  = 4'd8;
    localparam logic [PC_W-1:0] PC_FILT      = 4'd9;
    localparam logic [PC_W-1:0] PC_NOISE_MUL = 4'd10;
    localparam logic [PC_W-1:0] PC_LEVEL     = 4'd11;
    localparam logic [PC_W-1:0] PC_OUT_MUL   = 4'd12;
    localparam logic [PC_W-1:0] PC_OUT       = 4'd13;
    localparam logic [PC_W-1:0] PC_ZERO      = 4'd14;

    typedef struct packed {
        logic [2:0]      mul_sel;
        logic [3:0]      wb_sel;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
        logic            last;
    } ctrl_word_t;

    // Microprogram: one control word per step
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{MUL_NONE, WB_NONE, COND_NONE, PC_CHECK, 1'b0};
        unique case (pc)
            PC_CHECK:     w = '{MUL_NONE, WB_INIT, COND_DEPTH_ZERO, PC_ZERO, 1'b0};
            PC_LOOP:      w = '{MUL_BT_K, WB_NONE, COND_NONE, PC_CHECK, 1'b0};
            PC_PHASE:     w = '{MUL_NONE, WB_PHASE, COND_NONE, PC_CHECK, 1'b0};
            PC_ROM:       w = '{MUL_NONE, WB_ROM, COND_NONE, PC_CHECK, 1'b0};
            PC_ACC:       w = '{MUL_NONE, WB_ACC, COND_LANE_MORE, PC_LOOP, 1'b0};
            PC_LFO_MUL:   w = '{MUL_SUM_INV, WB_NONE, COND_NONE, PC_CHECK, 1'b0};
            PC_LFO:       w = '{MUL_BT_GAIN, WB_LFO, COND_NONE, PC_CHECK, 1'b0};
            PC_GAIN:      w = '{MUL_NONE, WB_GAIN, COND_NONE, PC_CHECK, 1'b0};
            PC_FILT_MUL:  w = '{MUL_G_DIFF, WB_NONE, COND_NONE, PC_CHECK, 1'b0};
            PC_FILT:      w = '{MUL_NONE, WB_FILT, COND_NONE, PC_CHECK, 1'b0};
            PC_NOISE_MUL: w = '{MUL_FILT_P2, WB_NONE, COND_NONE, PC_CHECK, 1'b0};
            PC_LEVEL:     w = '{MUL_NONE, WB_LEVEL, COND_NONE, PC_CHECK, 1'b0};
            PC_OUT_MUL:   w = '{MUL_LEV_DEPTH, WB_NONE, COND_NONE, PC_CHECK, 1'b0};
            PC_OUT:       w = '{MUL_NONE, WB_OUT, COND_NONE, PC_CHECK, 1'b1};
            PC_ZERO:      w = '{MUL_NONE, WB_ZERO, COND_NONE, PC_CHECK, 1'b1};
            default:      w = '{MUL_NONE, WB_NONE, COND_NONE, PC_CHECK, 1'b1};
        endcase
        return w;
    endfunction

endpackage

/* design/lfo_noise_drift_generator.sv */
// Drift generator: microcoded sequencer over one shared multiplier and a sine ROM.
// A word runs through the whole microprogram before its result is registered; zero depth takes a short path.
// A new word is accepted only once the previous one has finished; the three passes of the
// phase/sine loop and the single shared multiplier set the length of the program.
// A finished result waits in the output register until taken; the next word is accepted meanwhile.
// Reset (aresetn low, synchronous): phases and filter cleared, block_time = 195225, no word pending.
module lfo_noise_drift_generator #(
    parameter int PHASE_BITS       = lndg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = lndg_pkg::SINE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration: block_time
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lndg_pkg::BT_W-1:0]    cfg_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lndg_pkg::TDATA_W-1:0] s_tdata,   // [16:0] depth, [32:17] noise_sample
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lndg_pkg::TDATA_W-1:0] m_tdata    // [16:0] drift_out, [33:17] drift_level
);

    localparam int SH      = 40 - PHASE_BITS;
    localparam int FOUR_D  = 4 * SINE_TABLE_DEPTH;
    localparam int IDX_W   = $clog2(FOUR_D);
    localparam int AW      = $clog2(SINE_TABLE_DEPTH);
    localparam int RW      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IP_W    = PHASE_BITS + IDX_W;
    localparam int RND_W   = lndg_pkg::PROD_W + 1;
    localparam logic [63:0] DEPTH_64 = 64'(SINE_TABLE_DEPTH);

    typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Quarter-wave sine entry in Q1.15, Taylor series in Q30
    function automatic logic [15:0] sine_entry(input logic [31:0] i);
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        one = 64'd1 << 30;
        x   = (64'(lndg_pkg::HALF_PI_Q30) * 64'(i)) / DEPTH_64;
        x2  = (x * x) >> 30;
        t   = one - x2 / 64'd72;
        t   = one - ((x2 * t) >> 30) / 64'd42;
        t   = one - ((x2 * t) >> 30) / 64'd20;
        t   = one - ((x2 * t) >> 30) / 64'd6;
        s   = (x * t) >> 30;
        e   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return (e > 64'd32767) ? lndg_pkg::SINE_PEAK : e[15:0];
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine_entry(32'(i));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    // control
    logic                        busy_reg;
    logic [lndg_pkg::PC_W-1:0]   pc_reg;
    logic [lndg_pkg::PC_W-1:0]   pc_next;
    logic                        m_tvalid_reg;
    lndg_pkg::ctrl_word_t        word;
    logic                        out_free;
    logic                        step_en;
    logic                        take_jump;
    logic                        s_accept;

    // state
    logic [lndg_pkg::BT_W-1:0]          bt_reg;
    logic [PHASE_BITS-1:0]              phase_reg [3];
    logic signed [lndg_pkg::FILT_W-1:0] filt_reg;

    // datapath
    logic [lndg_pkg::DEPTH_W-1:0]         depth_reg;
    logic signed [lndg_pkg::NOISE_W-1:0]  noise_reg;
    logic [1:0]                           lane_reg;
    logic signed [lndg_pkg::ACC_W-1:0]    acc_reg;
    logic signed [lndg_pkg::LFO_W-1:0]    lfo_reg;
    logic [lndg_pkg::GAIN_W-1:0]          gain_reg;
    logic [lndg_pkg::DEPTH_W-1:0]         lev_reg;
    logic signed [lndg_pkg::PROD_W-1:0]   prod_reg;
    logic [15:0]                          rom_reg;
    logic                                 neg_reg;
    logic                                 full_reg;
    logic [lndg_pkg::DEPTH_W-1:0]         drift_out_reg;
    logic [lndg_pkg::DEPTH_W-1:0]         drift_level_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && !busy_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'd0, drift_level_reg, drift_out_reg};

    // sequencer
    assign word     = lndg_pkg::ucode(pc_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign step_en  = busy_reg && (!word.last || out_free);

    always_comb begin
        unique case (word.cond)
            lndg_pkg::COND_DEPTH_ZERO: take_jump = (depth_reg == '0);
            lndg_pkg::COND_LANE_MORE:  take_jump = (lane_reg != 2'd2);
            default:                   take_jump = 1'b0;
        endcase
        pc_next = take_jump ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pc_reg       <= lndg_pkg::PC_CHECK;
            m_tvalid_reg <= 1'b0;
        end else begin
            // result valid: set by the last step, cleared when taken
            if (step_en && word.last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_accept) begin
                busy_reg <= 1'b1;
                pc_reg   <= lndg_pkg::PC_CHECK;
            end else if (step_en) begin
                if (word.last) begin
                    busy_reg <= 1'b0;
                end else begin
                    pc_reg <= pc_next;
                end
            end
        end
    end

    // shared multiplier operand select
    logic signed [lndg_pkg::MUL_A_W-1:0] mul_a;
    logic signed [lndg_pkg::MUL_B_W-1:0] mul_b;
    logic signed [lndg_pkg::MUL_B_W-1:0] k_lane;
    logic signed [lndg_pkg::DIFF_W-1:0]  diff;
    logic signed [lndg_pkg::PROD_W-1:0]  mul_p;

    always_comb begin
        unique case (lane_reg)
            2'd0:    k_lane = lndg_pkg::K_SLOW;
            2'd1:    k_lane = lndg_pkg::K_MID;
            default: k_lane = lndg_pkg::K_FAST;
        endcase
    end

    assign diff = lndg_pkg::DIFF_W'(signed'({noise_reg, 2'b00})) - lndg_pkg::DIFF_W'(filt_reg);

    always_comb begin
        unique case (word.mul_sel)
            lndg_pkg::MUL_BT_K: begin
                mul_a = lndg_pkg::MUL_A_W'({1'b0, bt_reg});
                mul_b = k_lane;
            end
            lndg_pkg::MUL_SUM_INV: begin
                mul_a = lndg_pkg::MUL_A_W'(acc_reg);
                mul_b = lndg_pkg::INV175;
            end
            lndg_pkg::MUL_BT_GAIN: begin
                mul_a = lndg_pkg::MUL_A_W'({1'b0, bt_reg});
                mul_b = lndg_pkg::GAIN_C;
            end
            lndg_pkg::MUL_G_DIFF: begin
                mul_a = lndg_pkg::MUL_A_W'(diff);
                mul_b = lndg_pkg::MUL_B_W'({1'b0, gain_reg});
            end
            lndg_pkg::MUL_FILT_P2: begin
                mul_a = lndg_pkg::MUL_A_W'(filt_reg);
                mul_b = lndg_pkg::POINT2;
            end
            lndg_pkg::MUL_LEV_DEPTH: begin
                mul_a = lndg_pkg::MUL_A_W'({1'b0, lev_reg});
                mul_b = lndg_pkg::MUL_B_W'({1'b0, depth_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = lndg_pkg::PROD_W'(mul_a) * lndg_pkg::PROD_W'(mul_b);

    // rounded views of the product (floor after the shift)
    logic signed [RND_W-1:0] rnd16;
    logic signed [RND_W-1:0] rnd17;
    logic signed [RND_W-1:0] rnd24;
    logic        [RND_W-1:0] rnd_ph;

    assign rnd16  = RND_W'(prod_reg) + RND_W'(32'sd32768);
    assign rnd17  = RND_W'(prod_reg) + RND_W'(32'sd65536);
    assign rnd24  = RND_W'(prod_reg) + RND_W'(32'sd8388608);
    assign rnd_ph = RND_W'(prod_reg) + (RND_W'(1) << (SH - 1));

    // phase advance for the current lane
    logic [PHASE_BITS-1:0] phase_cur;
    logic [PHASE_BITS-1:0] phase_next;

    assign phase_cur  = phase_reg[lane_reg];
    assign phase_next = phase_cur + rnd_ph[SH +: PHASE_BITS];

    // sine table address from the phase: quadrant and offset
    logic [IP_W-1:0]  idx_prod;
    logic [IDX_W-1:0] idx;
    logic [1:0]       quad;
    logic [RW-1:0]    r_off;
    logic [RW-1:0]    addr;
    logic [AW-1:0]    rom_addr;
    logic             addr_full;

    localparam logic [IDX_W-1:0] D1 = IDX_W'(SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0] D2 = IDX_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0] D3 = IDX_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [RW-1:0]    DR = RW'(SINE_TABLE_DEPTH);

    assign idx_prod = IP_W'(phase_cur) * IP_W'(FOUR_D);
    assign idx      = idx_prod[PHASE_BITS +: IDX_W];

    always_comb begin
        priority if (idx >= D3) begin
            quad  = 2'd3;
            r_off = RW'(idx - D3);
        end else if (idx >= D2) begin
            quad  = 2'd2;
            r_off = RW'(idx - D2);
        end else if (idx >= D1) begin
            quad  = 2'd1;
            r_off = RW'(idx - D1);
        end else begin
            quad  = 2'd0;
            r_off = RW'(idx);
        end
        addr      = quad[0] ? DR - r_off : r_off;
        addr_full = (addr == DR);
        rom_addr  = addr_full ? '0 : addr[AW-1:0];
    end

    // signed, weighted sine sample for the accumulator
    logic signed [16:0]                 sine_mag;
    logic signed [16:0]                 sine_val;
    logic signed [lndg_pkg::ACC_W-1:0]  sine_wt;

    always_comb begin
        sine_mag = full_reg ? 17'sd32767 : signed'({1'b0, rom_reg});
        sine_val = neg_reg ? -sine_mag : sine_mag;
        unique case (lane_reg)
            2'd0:    sine_wt = lndg_pkg::ACC_W'(sine_val) <<< 2;
            2'd1:    sine_wt = lndg_pkg::ACC_W'(sine_val) <<< 1;
            default: sine_wt = lndg_pkg::ACC_W'(sine_val);
        endcase
    end

    // filter update, clamped to Q1.17
    logic signed [19:0] filt_step;
    logic signed [20:0] filt_sum;
    logic signed [lndg_pkg::FILT_W-1:0] filt_new;

    assign filt_step = rnd16[16 +: 20];
    assign filt_sum  = 21'(filt_reg) + 21'(filt_step);

    always_comb begin
        priority if (filt_sum > 21'(lndg_pkg::FILT_MAX)) begin
            filt_new = lndg_pkg::FILT_MAX;
        end else if (filt_sum < 21'(lndg_pkg::FILT_MIN)) begin
            filt_new = lndg_pkg::FILT_MIN;
        end else begin
            filt_new = filt_sum[lndg_pkg::FILT_W-1:0];
        end
    end

    // filter gain, saturated to unity
    logic [23:0]                  gain_full;
    logic [lndg_pkg::GAIN_W-1:0]  gain_new;

    assign gain_full = rnd24[24 +: 24];
    assign gain_new  = (gain_full > 24'(lndg_pkg::FULL_SCALE)) ? lndg_pkg::FULL_SCALE
                                                               : gain_full[16:0];

    // blend, map to 0..1 and clamp
    logic signed [15:0]  noise_part;
    logic signed [18:0]  raw;
    logic signed [19:0]  lev_sum;
    logic signed [18:0]  lev_half;
    logic [lndg_pkg::DEPTH_W-1:0] lev_new;

    assign noise_part = rnd17[17 +: 16];
    assign raw        = 19'(lfo_reg) + 19'(noise_part);
    assign lev_sum    = 20'(raw) + 20'sd65537;
    assign lev_half   = lev_sum[19:1];

    always_comb begin
        priority if (lev_half < 19'sd0) begin
            lev_new = '0;
        end else if (lev_half > 19'sd65536) begin
            lev_new = lndg_pkg::FULL_SCALE;
        end else begin
            lev_new = lev_half[16:0];
        end
    end

    // configuration register and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bt_reg       <= lndg_pkg::BT_RESET;
            phase_reg[0] <= '0;
            phase_reg[1] <= '0;
            phase_reg[2] <= '0;
            filt_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                bt_reg <= cfg_data;
            end
            if (step_en && word.wb_sel == lndg_pkg::WB_PHASE) begin
                phase_reg[lane_reg] <= phase_next;
            end
            if (step_en && word.wb_sel == lndg_pkg::WB_FILT) begin
                filt_reg <= filt_new;
            end
        end
    end

    // input capture, depth saturated to full scale
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            depth_reg <= (s_tdata[16:0] > lndg_pkg::FULL_SCALE) ? lndg_pkg::FULL_SCALE
                                                                : s_tdata[16:0];
            noise_reg <= signed'(s_tdata[32:17]);
        end
    end

    // multiplier output register
    always_ff @(posedge aclk) begin
        if (step_en && word.mul_sel != lndg_pkg::MUL_NONE) begin
            prod_reg <= mul_p;
        end
    end

    // sine ROM read
    always_ff @(posedge aclk) begin
        if (step_en && word.wb_sel == lndg_pkg::WB_ROM) begin
            rom_reg  <= SINE_ROM[rom_addr];
            neg_reg  <= quad[1];
            full_reg <= addr_full;
        end
    end

    // datapath write-back
    always_ff @(posedge aclk) begin
        if (step_en) begin
            unique case (word.wb_sel)
                lndg_pkg::WB_INIT: begin
                    lane_reg <= 2'd0;
                    acc_reg  <= '0;
                end
                lndg_pkg::WB_ACC: begin
                    acc_reg  <= acc_reg + sine_wt;
                    lane_reg <= lane_reg + 2'd1;
                end
                lndg_pkg::WB_LFO: begin
                    lfo_reg <= rnd17[17 +: lndg_pkg::LFO_W];
                end
                lndg_pkg::WB_GAIN: begin
                    gain_reg <= gain_new;
                end
                lndg_pkg::WB_LEVEL: begin
                    lev_reg <= lev_new;
                end
                lndg_pkg::WB_OUT: begin
                    drift_out_reg   <= rnd16[16 +: lndg_pkg::DEPTH_W];
                    drift_level_reg <= lev_reg;
                end
                lndg_pkg::WB_ZERO: begin
                    drift_out_reg   <= '0;
                    drift_level_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
